@@ sv/sorted_sequence_merge_core_assert.svh @@
// Assertion macros shared by the merge core.
`ifndef SORTED_SEQUENCE_MERGE_CORE_ASSERT_SVH
`define SORTED_SEQUENCE_MERGE_CORE_ASSERT_SVH

// Condition that must hold in the same cycle as its trigger.
`define SMERGE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("merge core check failed in the same cycle");

// Condition that must hold in the cycle after its trigger.
`define SMERGE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("merge core check failed one cycle later");

`endif

@@ sv/smerge_pkg.sv @@
`timescale 1ns / 1ps

package smerge_pkg;

  localparam int DATA_W = 32;
  localparam int FIFO_DEPTH_DEFAULT = 256;

  localparam logic [1:0] KIND_PUSH_FIRST  = 2'd0;
  localparam logic [1:0] KIND_PUSH_SECOND = 2'd1;

  typedef enum logic [1:0] {
    ST_PUSH_OK = 2'd0,
    ST_POPPED  = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

endpackage

@@ sv/smerge_ram.sv @@
`timescale 1ns / 1ps

module smerge_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/sorted_sequence_merge_core.sv @@
`timescale 1ns / 1ps

// Two-way merge of ascending sequences of signed 32-bit values. Each input
// transfer carries a kind and a value: kind 0 pushes the value into the first
// FIFO, kind 1 into the second, and any kind with bit 1 set is a pop. Every
// input transfer produces exactly one output transfer. A push answers with
// status 0 (stored) or 3 (dropped because that FIFO holds FIFO_DEPTH values),
// and source names the FIFO addressed. A pop emits the smaller of the two FIFO
// heads with status 1; on equal heads the second FIFO goes first, and when one
// FIFO is empty the other drains in order. A pop with both FIFOs empty answers
// status 2 with value and source zero. Each FIFO lives in its own simple
// dual-port synchronous RAM (one write port, one read port) with registered
// read data, so a push or a pop that finds both FIFOs empty is answered from
// the idle state, while a pop that returns a value first reads both head
// entries and then, in the pop state, compares them and advances the winning
// head. The result sits in an output register, so the next item can be taken
// in the same cycle that the previous result leaves. There is no clearing
// pass after reset; the FIFOs start empty and only entries written by pushes
// are ever read.
module sorted_sequence_merge_core #(
  parameter int FIFO_DEPTH = smerge_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             kind,
  input  logic signed [smerge_pkg::DATA_W-1:0]   value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [smerge_pkg::DATA_W-1:0]   result_value,
  output logic [1:0]                             status,
  output logic                                   source
);

  import smerge_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t state;

  logic [PW-1:0] first_head;
  logic [PW-1:0] first_tail;
  logic [CW-1:0] first_count;
  logic [PW-1:0] second_head;
  logic [PW-1:0] second_tail;
  logic [CW-1:0] second_count;

  logic [DATA_W-1:0] first_rdata;
  logic [DATA_W-1:0] second_rdata;

  logic accept;
  logic out_done;
  logic is_push_first;
  logic is_push_second;
  logic first_full;
  logic second_full;
  logic have_first;
  logic have_second;
  logic take_first;
  logic first_we;
  logic second_we;

  // Advance a read or write position, wrapping at the FIFO depth.
  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] pos);
    logic [PW-1:0] nxt;
    if (pos == PW'(FIFO_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = pos + 1'b1;
    end
    return nxt;
  endfunction

  // The core holds off input while a pop is comparing heads, and while a
  // finished result is still waiting for the downstream side.
  assign out_done = out_valid && !out_stall;
  assign in_stall = (state == S_POP) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign is_push_first  = (kind == KIND_PUSH_FIRST);
  assign is_push_second = (kind == KIND_PUSH_SECOND);

  assign first_full  = (first_count == CW'(FIFO_DEPTH));
  assign second_full = (second_count == CW'(FIFO_DEPTH));
  assign have_first  = (first_count != '0);
  assign have_second = (second_count != '0);

  assign first_we  = accept && is_push_first && !first_full;
  assign second_we = accept && is_push_second && !second_full;

  // On equal heads the second sequence wins, so the first side is taken only
  // when it is strictly smaller or the second side has run dry.
  assign take_first = have_first &&
                      (!have_second || ($signed(first_rdata) < $signed(second_rdata)));

  // Both RAMs read their head entry every cycle; the pop state uses the data
  // captured during the cycle the pop was accepted.
  smerge_ram #(
    .WIDTH(DATA_W),
    .DEPTH(FIFO_DEPTH)
  ) u_first_ram (
    .clk  (clk),
    .we   (first_we),
    .waddr(first_tail),
    .wdata(value),
    .raddr(first_head),
    .rdata(first_rdata)
  );

  smerge_ram #(
    .WIDTH(DATA_W),
    .DEPTH(FIFO_DEPTH)
  ) u_second_ram (
    .clk  (clk),
    .we   (second_we),
    .waddr(second_tail),
    .wdata(value),
    .raddr(second_head),
    .rdata(second_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      first_head   <= '0;
      first_tail   <= '0;
      first_count  <= '0;
      second_head  <= '0;
      second_tail  <= '0;
      second_count <= '0;
    end else begin
      if (out_done) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_push_first) begin
              out_valid    <= 1'b1;
              result_value <= '0;
              source       <= 1'b0;
              if (first_full) begin
                status <= ST_FULL;
              end else begin
                status      <= ST_PUSH_OK;
                first_tail  <= wrap_inc(first_tail);
                first_count <= first_count + 1'b1;
              end
            end else if (is_push_second) begin
              out_valid    <= 1'b1;
              result_value <= '0;
              source       <= 1'b1;
              if (second_full) begin
                status <= ST_FULL;
              end else begin
                status       <= ST_PUSH_OK;
                second_tail  <= wrap_inc(second_tail);
                second_count <= second_count + 1'b1;
              end
            end else if (!have_first && !have_second) begin
              out_valid    <= 1'b1;
              result_value <= '0;
              source       <= 1'b0;
              status       <= ST_EMPTY;
            end else begin
              state <= S_POP;
            end
          end
        end
        S_POP: begin
          // The output register is free here: a pop is only accepted when
          // the previous result is gone or leaves in that same cycle.
          out_valid <= 1'b1;
          status    <= ST_POPPED;
          state     <= S_IDLE;
          if (take_first) begin
            result_value <= first_rdata;
            source       <= 1'b0;
            first_head   <= wrap_inc(first_head);
            first_count  <= first_count - 1'b1;
          end else begin
            result_value <= second_rdata;
            source       <= 1'b1;
            second_head  <= wrap_inc(second_head);
            second_count <= second_count - 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "sorted_sequence_merge_core_assert.svh"

  // A pop only reaches the compare step when some FIFO holds a value.
  `SMERGE_ASSERT_NOW(a_pop_has_data, state == S_POP, have_first || have_second)

  // The output register must be empty when the compare step fills it.
  `SMERGE_ASSERT_NOW(a_pop_out_free, state == S_POP, !out_valid)

  // Every compare step delivers a popped value in the next cycle.
  `SMERGE_ASSERT_NEXT(a_pop_result, state == S_POP,
                      out_valid && status == ST_POPPED && state == S_IDLE)

  // Occupancy never passes the depth of either FIFO.
  `SMERGE_ASSERT_NOW(a_count_bound, 1'b1,
                     first_count <= CW'(FIFO_DEPTH) && second_count <= CW'(FIFO_DEPTH))

endmodule

@@ tb/tb_sorted_sequence_merge_core.sv @@
`timescale 1ns / 1ps

module tb_sorted_sequence_merge_core;
  import smerge_pkg::*;

  localparam int FIFO_DEPTH = FIFO_DEPTH_DEFAULT;

  // Any kind with bit 1 set is a pop. Both encodings are exercised.
  localparam logic [1:0] KIND_POP     = 2'd2;
  localparam logic [1:0] KIND_POP_ALT = 2'd3;

  // The receiver holds off this long once during the fill phase, which is far
  // longer than the core can absorb, so its input stall must come up.
  localparam int PRESSURE_HOLD = 150;
  // Cycles without any transfer on either side before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 1000;
  // Settling time after the last expected result, long enough to catch any
  // stray extra transfer from the core.
  localparam int DRAIN_CYCLES = 10;

  typedef logic signed [DATA_W-1:0] word_q_t[$];

  // One result transfer as the core should produce it.
  typedef struct {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic                     source;
  } merge_result_t;

  // Shadow copy of both FIFOs plus the results still owed by the core. Every
  // accepted input transfer is applied here at once, which is exact because
  // the core answers items strictly in order, one result each.
  class merge_predictor;
    logic signed [DATA_W-1:0] first_fifo[$];
    logic signed [DATA_W-1:0] second_fifo[$];
    merge_result_t            pending_results[$];
    int unsigned              depth;
    int                       mismatches;

    function new(int unsigned fifo_depth);
      depth = fifo_depth;
      mismatches = 0;
    endfunction

    function int occupancy();
      return first_fifo.size() + second_fifo.size();
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_accepted_item(logic [1:0] item_kind,
                                     logic signed [DATA_W-1:0] item_value);
      merge_result_t r;
      bit            take_first;
      r.value = '0;
      r.status = ST_PUSH_OK;
      r.source = 1'b0;
      if (item_kind[1]) begin
        if (first_fifo.size() == 0 && second_fifo.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // Signed compare; a tie goes to the second sequence.
          take_first = first_fifo.size() != 0 &&
                       (second_fifo.size() == 0 || first_fifo[0] < second_fifo[0]);
          r.status = ST_POPPED;
          if (take_first) begin
            r.value = first_fifo.pop_front();
            r.source = 1'b0;
          end else begin
            r.value = second_fifo.pop_front();
            r.source = 1'b1;
          end
        end
      end else if (item_kind == KIND_PUSH_FIRST) begin
        r.source = 1'b0;
        if (first_fifo.size() >= depth) r.status = ST_FULL;
        else first_fifo.push_back(item_value);
      end else begin
        r.source = 1'b1;
        if (second_fifo.size() >= depth) r.status = ST_FULL;
        else second_fifo.push_back(item_value);
      end
      pending_results.push_back(r);
    endfunction

    task report(string what);
      if (mismatches < 40) $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic signed [DATA_W-1:0] got_value, logic [1:0] got_status,
                      logic got_source);
      merge_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing owed: value %0d status %0d source %0d",
                         got_value, got_status, got_source));
        return;
      end
      want = pending_results.pop_front();
      if (got_value !== want.value)
        report($sformatf("result_value %0d, expected %0d", got_value, want.value));
      if (got_status !== want.status)
        report($sformatf("status %0d, expected %s", got_status, want.status.name()));
      if (got_source !== want.source)
        report($sformatf("source %0d, expected %0d", got_source, want.source));
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               kind = KIND_PUSH_FIRST;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] result_value;
  logic [1:0]               status;
  logic                     source;

  merge_predictor predictor;

  // Set for the closing phases, where neither side inserts gaps.
  bit calm = 1'b0;
  // Bumped by the stimulus to ask the receiver for one long hold-off.
  int pressure_reqs = 0;
  int pressure_seen = 0;
  int hold_left = 0;
  int burst_left = 0;
  int stuck_cycles = 0;

  sorted_sequence_merge_core #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_value(result_value),
    .status(status),
    .source(source)
  );

  always #4 clk = ~clk;

  // Offers one item and returns at the edge where it is taken. Before the
  // offer the sender may drop valid for a short random burst. Everything read
  // here right after the edge still holds its value from before that edge.
  task automatic offer_item(input logic [1:0] item_kind,
                            input logic signed [DATA_W-1:0] item_value);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= item_kind;
    value <= item_value;
    do @(posedge clk); while (in_stall);
    predictor.note_accepted_item(item_kind, item_value);
  endtask

  // An ascending run of n values, either over the whole signed range or
  // squeezed into a few values so that equal heads come up often.
  function automatic word_q_t sorted_run(int n, bit narrow);
    word_q_t                  run;
    logic signed [DATA_W-1:0] w;
    for (int i = 0; i < n; i++) begin
      if (narrow) begin
        w = $urandom_range(0, 6);
        w = w - 3;
      end else begin
        w = $urandom;
      end
      run.push_back(w);
    end
    run.sort();
    return run;
  endfunction

  // One merge: two sorted runs are pushed in a random interleaving, then pops
  // follow until both FIFOs are empty, and a final pop must find them empty.
  // Optional early pops and random junk items break the pattern now and then.
  task automatic merge_phase(int n_first, int n_second, bit narrow, bit mid_pops,
                             bit noisy);
    word_q_t run_first;
    word_q_t run_second;
    int      pick;
    run_first = sorted_run(n_first, narrow);
    run_second = sorted_run(n_second, narrow);
    while (run_first.size() + run_second.size() > 0) begin
      pick = $urandom_range(0, 19);
      if (noisy && pick == 0)
        offer_item(2'($urandom_range(0, 3)), $urandom);
      else if (mid_pops && pick == 1)
        offer_item(KIND_POP, $urandom);
      else if (run_second.size() == 0 ||
               (run_first.size() != 0 && $urandom_range(0, 1) == 0))
        offer_item(KIND_PUSH_FIRST, run_first.pop_front());
      else
        offer_item(KIND_PUSH_SECOND, run_second.pop_front());
    end
    while (predictor.occupancy() > 0) begin
      if (noisy && $urandom_range(0, 19) == 0)
        offer_item(2'($urandom_range(0, 3)), $urandom);
      else
        offer_item(($urandom_range(0, 3) == 0) ? KIND_POP_ALT : KIND_POP, $urandom);
    end
    offer_item(KIND_POP, $urandom);
  endtask

  // Receiver: checks each result transfer, then decides the stall for the
  // next cycle. A pending pressure request wins over the short random bursts.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      predictor.check_result(result_value, status, source);
    if (pressure_reqs != pressure_seen) begin
      pressure_seen = pressure_reqs;
      hold_left = PRESSURE_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(1, 5) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // A run that stops moving on both sides for too long has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    predictor = new(FIFO_DEPTH);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Pops right out of reset must report that both sides are empty, with
    // either pop encoding.
    offer_item(KIND_POP, 32'sh7FFF_FFFF);
    offer_item(KIND_POP_ALT, 32'sh8000_0000);

    // Extremes of the signed range: the most negative value must win.
    offer_item(KIND_PUSH_FIRST, 32'sh7FFF_FFFF);
    offer_item(KIND_PUSH_SECOND, 32'sh8000_0000);
    offer_item(KIND_POP_ALT, '0);
    offer_item(KIND_POP, '0);
    offer_item(KIND_POP, '0);

    // Equal heads: the second sequence goes first.
    offer_item(KIND_PUSH_FIRST, -32'sd1);
    offer_item(KIND_PUSH_SECOND, -32'sd1);
    offer_item(KIND_POP, '0);
    offer_item(KIND_POP, '0);

    // A tie that only shows up after the first head has left, then one side
    // draining alone and a pop on empty FIFOs.
    offer_item(KIND_PUSH_FIRST, 32'sd0);
    offer_item(KIND_PUSH_FIRST, 32'sd5);
    offer_item(KIND_PUSH_SECOND, 32'sd5);
    offer_item(KIND_POP, '0);
    offer_item(KIND_POP, '0);
    offer_item(KIND_POP, '0);
    offer_item(KIND_POP, '0);

    // Alternating bit patterns on both sides.
    offer_item(KIND_PUSH_FIRST, 32'shAAAA_AAAA);
    offer_item(KIND_PUSH_SECOND, 32'sh5555_5555);
    offer_item(KIND_POP_ALT, 32'sh5555_5555);
    offer_item(KIND_POP, 32'shAAAA_AAAA);

    // Short merges with early pops and some junk mixed in.
    repeat (2) merge_phase($urandom_range(0, 10), $urandom_range(0, 10),
                           $urandom_range(0, 1), 1'b1, 1'b1);

    // Fill the first FIFO past its depth, so its last pushes are dropped,
    // and then merge everything out. The receiver holds off at the start,
    // so the core backs up and must stall its input.
    pressure_reqs++;
    merge_phase(FIFO_DEPTH + 2, 4, 1'b0, 1'b0, 1'b0);

    merge_phase($urandom_range(1, 12), $urandom_range(1, 12), 1'b1, 1'b1, 1'b1);

    // Closing phases run back to back with no gaps on either side.
    calm = 1'b1;
    repeat (2) merge_phase($urandom_range(1, 12), $urandom_range(1, 12),
                           $urandom_range(0, 1), 1'b1, 1'b1);

    in_valid <= 1'b0;
    while (predictor.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predictor.mismatches == 0 && predictor.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sorted_sequence_merge_core.f @@
+incdir+sv
sv/smerge_pkg.sv
sv/smerge_ram.sv
sv/sorted_sequence_merge_core.sv
tb/tb_sorted_sequence_merge_core.sv
